// File: src/lsfw_pkg.sv
package lsfw_pkg;

   localparam logic [15:0] DEFAULT_PHASE_TICKS = 16'd5;
   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_PHASE_TICKS = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S0, ST_S1, ST_S2,
      ST_B0, ST_B1, ST_B2,
      ST_A0, ST_A1, ST_A2,
      ST_WAIT,
      ST_P0, ST_P1, ST_P2
   } step_type;

   typedef enum logic {
      KIND_TICK,
      KIND_OFFER
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       sda_sample;
   } item_type;

endpackage

// File: src/lsfw_front.sv
module lsfw_front #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               req_sda_sample,
   output logic               q_valid,
   output lsfw_pkg::item_type q_item,
   input  logic               q_pop
);
   import lsfw_pkg::*;

   localparam int unsigned PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   item_type               incoming;
   logic                   push;
   logic                   pop;

   always_comb begin
      incoming.kind       = req_action ? KIND_OFFER : KIND_TICK;
      incoming.data_byte  = req_data_byte;
      incoming.last_byte  = req_last_byte;
      incoming.sda_sample = req_sda_sample;
   end

   assign req_stall = (count_ff == CNT_FULL);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !q_pop) |=> req_stall)
      else $error("full queue drained without a pop");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |=> q_valid)
      else $error("queue empty after a transfer in");
`endif

endmodule

// File: src/lsfw_back.sv
module lsfw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        phase_ticks,
   input  logic               q_valid,
   input  lsfw_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_clock_level,
   output logic               rsp_data_level,
   output logic               rsp_want_byte,
   output logic               rsp_frame_done,
   output logic               rsp_frame_status
);
   import lsfw_pkg::*;

   localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

   step_type    step_ff, step_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  bit_ff, bit_in;
   logic        final_ff, final_in;
   logic        abort_ff, abort_in;
   logic        done_in;

   logic        clk_lvl, dat_lvl, want;
   logic        take;
   logic [15:0] limit;
   logic [16:0] count_inc;
   logic        waiting;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_clock_ff, rsp_data_ff, rsp_want_ff, rsp_done_ff, rsp_status_ff;

   assign take      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = take;
   assign limit     = (phase_ticks == '0) ? 16'd1 : phase_ticks;
   assign count_inc = {1'b0, count_ff} + 17'd1;
   assign waiting   = (step_ff == ST_IDLE) || (step_ff == ST_WAIT);

   // next state
   always_comb begin
      step_in  = step_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      final_in = final_ff;
      abort_in = abort_ff;
      done_in  = 1'b0;
      if (q_item.kind == KIND_OFFER) begin
         if (waiting) begin
            if (step_ff == ST_IDLE) begin
               abort_in = 1'b0;
               step_in  = ST_S0;
            end else begin
               step_in  = ST_B0;
            end
            shift_in = q_item.data_byte;
            final_in = q_item.last_byte;
            bit_in   = '0;
            count_in = '0;
         end
      end else if (!waiting) begin
         if (count_inc >= {1'b0, limit}) begin
            count_in = '0;
            unique case (step_ff)
               ST_S0: step_in = ST_S1;
               ST_S1: step_in = ST_S2;
               ST_S2: step_in = ST_B0;
               ST_B0: step_in = ST_B1;
               ST_B1: step_in = ST_B2;
               ST_B2: begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  if (bit_ff == LAST_BIT) begin
                     bit_in  = '0;
                     step_in = ST_A0;
                  end else begin
                     bit_in  = bit_ff + 1'b1;
                     step_in = ST_B0;
                  end
               end
               ST_A0: step_in = ST_A1;
               ST_A1: begin
                  if (q_item.sda_sample) begin
                     abort_in = 1'b1;
                     step_in  = ST_P0;
                  end else begin
                     step_in  = ST_A2;
                  end
               end
               ST_A2: step_in = final_ff ? ST_P0 : ST_WAIT;
               ST_P0: step_in = ST_P1;
               ST_P1: step_in = ST_P2;
               ST_P2: begin
                  step_in = ST_IDLE;
                  done_in = 1'b1;
               end
               default: step_in = step_ff;
            endcase
         end else begin
            count_in = count_inc[15:0];
         end
      end
   end

   // pin levels after the item
   always_comb begin
      want = (step_in == ST_IDLE) || (step_in == ST_WAIT);
      unique case (step_in)
         ST_S0:   begin clk_lvl = 1'b1; dat_lvl = 1'b1;        end
         ST_S1:   begin clk_lvl = 1'b1; dat_lvl = 1'b0;        end
         ST_S2:   begin clk_lvl = 1'b0; dat_lvl = 1'b0;        end
         ST_B0:   begin clk_lvl = 1'b0; dat_lvl = shift_in[0]; end
         ST_B1:   begin clk_lvl = 1'b1; dat_lvl = shift_in[0]; end
         ST_B2:   begin clk_lvl = 1'b0; dat_lvl = shift_in[0]; end
         ST_A0:   begin clk_lvl = 1'b0; dat_lvl = 1'b1;        end
         ST_A1:   begin clk_lvl = 1'b1; dat_lvl = 1'b1;        end
         ST_A2:   begin clk_lvl = 1'b0; dat_lvl = 1'b1;        end
         ST_WAIT: begin clk_lvl = 1'b0; dat_lvl = 1'b1;        end
         ST_P0:   begin clk_lvl = 1'b0; dat_lvl = 1'b0;        end
         ST_P1:   begin clk_lvl = 1'b1; dat_lvl = 1'b0;        end
         ST_P2:   begin clk_lvl = 1'b1; dat_lvl = 1'b1;        end
         default: begin clk_lvl = 1'b1; dat_lvl = 1'b1;        end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         count_ff     <= '0;
         shift_ff     <= '0;
         bit_ff       <= '0;
         final_ff     <= 1'b0;
         abort_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            step_ff  <= step_in;
            count_ff <= count_in;
            shift_ff <= shift_in;
            bit_ff   <= bit_in;
            final_ff <= final_in;
            abort_ff <= abort_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_clock_ff  <= clk_lvl;
         rsp_data_ff   <= dat_lvl;
         rsp_want_ff   <= want;
         rsp_done_ff   <= done_in;
         rsp_status_ff <= done_in & abort_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clock_level  = rsp_clock_ff;
   assign rsp_data_level   = rsp_data_ff;
   assign rsp_want_byte    = rsp_want_ff;
   assign rsp_frame_done   = rsp_done_ff;
   assign rsp_frame_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_done_idle_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_clock_ff && rsp_data_ff && rsp_want_ff))
      else $error("frame end without both lines released");
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> rsp_done_ff)
      else $error("failure status outside frame end");
   a_hold_without_take: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(step_ff) && $stable(count_ff))
      else $error("sequencer moved without a transfer");
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (take && q_item.kind == KIND_TICK && step_ff == ST_IDLE) |=> step_ff == ST_IDLE)
      else $error("tick left idle");
`endif

endmodule

// File: src/lsb_first_two_wire_frame_writer.sv
// Path: the input transfer writes the queue, and the transfer out of the queue then
// loads the output register; a stall holds the item in the queue before that load.
// Throughput: one item per cycle while rsp_stall is low; each item is a single sequencer update.
// A stalled result holds the output register; the queue takes QUEUE_DEPTH more transfers before req_stall.
// Reset (synchronous, active high): sequencer idle, queue empty, no result pending,
// phase_ticks back to 5.
module lsb_first_two_wire_frame_writer #(
   parameter int unsigned QUEUE_DEPTH = lsfw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   input  logic                                req_sda_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_clock_level,
   output logic                                rsp_data_level,
   output logic                                rsp_want_byte,
   output logic                                rsp_frame_done,
   output logic                                rsp_frame_status,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lsfw_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [lsfw_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [lsfw_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import lsfw_pkg::*;

   logic [15:0] phase_ticks_ff;
   logic        csr_write;
   logic        q_valid;
   logic        q_pop;
   item_type    q_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= DEFAULT_PHASE_TICKS;
      end else if (csr_write && paddr[2] == CSR_IDX_PHASE_TICKS) begin
         phase_ticks_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_PHASE_TICKS) begin
         prdata = {{(CSR_DATA_WIDTH-16){1'b0}}, phase_ticks_ff};
      end
   end

   lsfw_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .req_sda_sample (req_sda_sample),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   lsfw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .phase_ticks      (phase_ticks_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clock_level  (rsp_clock_level),
      .rsp_data_level   (rsp_data_level),
      .rsp_want_byte    (rsp_want_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule
